FILE: src/pwpi_pkg.sv
package pwpi_pkg;

	// width of the internal destination address arithmetic
	localparam int AddrWidth = 32;

	localparam logic [7:0] OP_RET      = 8'hc3;
	localparam logic [7:0] OP_LOAD     = 8'hb9;
	localparam logic [7:0] OP_ADVANCE  = 8'h05;
	localparam logic [7:0] OP_MOV32    = 8'h89;
	localparam logic [7:0] OP_MODRM    = 8'h48;
	localparam logic [7:0] OP_PREFIX16 = 8'h66;
	localparam logic [7:0] OP_MOV8     = 8'h88;
	localparam logic [7:0] OP_IMM8     = 8'hc6;
	localparam logic [7:0] OP_MODRM_IMM = 8'h40;
	localparam logic [7:0] OP_IMM32    = 8'hc7;
	localparam logic [31:0] ColorSpread = 32'h01010101;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_ADV,
		PH_COLOR,
		PH_F4_MOD,
		PH_F4_DISP,
		PH_P66,
		PH_F2_MOD,
		PH_F2_DISP,
		PH_F1_MOD,
		PH_F1_DISP,
		PH_I1_MOD,
		PH_I1_BODY,
		PH_I2_MOD,
		PH_I2_BODY,
		PH_I4_MOD,
		PH_I4_BODY
	} phase_t;

	typedef enum logic [1:0] {
		END_RUNNING,
		END_RETURN,
		END_MALFORMED,
		END_EXHAUSTED
	} end_code_t;

	typedef enum logic [1:0] {
		CFG_PROGRAM_KIND,
		CFG_FILL_COLOR,
		CFG_DESTINATION_BASE
	} cfg_index_t;

	typedef struct packed {
		logic        program_kind;
		logic [7:0]  fill_color;
		logic [31:0] destination_base;
	} cfg_t;

	typedef struct packed {
		phase_t                 phase;
		logic [2:0]             op_index;
		logic [31:0]            gather;
		logic [7:0]             disp;
		logic [AddrWidth-1:0]   base;
		logic [31:0]            color;
		logic                   loaded;
		logic                   halted;
	} parse_state_t;

	// parser state out of reset: idle and halted until a first byte
	localparam parse_state_t ParseReset = '{
		phase:    PH_IDLE,
		op_index: 3'd0,
		gather:   32'h0,
		disp:     8'h0,
		base:     '0,
		color:    32'h0,
		loaded:   1'b0,
		halted:   1'b1
	};

	typedef struct packed {
		logic        write_valid;
		logic [31:0] write_address;
		logic [31:0] write_data;
		logic [2:0]  byte_count;
		end_code_t   end_code;
	} result_t;

endpackage

FILE: src/pwpi_prog_if.sv
interface pwpi_prog_if;
	logic       valid;
	logic       ready;
	logic [7:0] program_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, program_byte, first_byte, last_byte, input ready);
	modport sink (input valid, program_byte, first_byte, last_byte, output ready);
endinterface

FILE: src/pwpi_result_if.sv
interface pwpi_result_if;
	logic        valid;
	logic        ready;
	logic        write_valid;
	logic [31:0] write_address;
	logic [31:0] write_data;
	logic [2:0]  byte_count;
	logic [1:0]  end_code;

	modport source (output valid, write_valid, write_address, write_data, byte_count,
		end_code, input ready);
	modport sink (input valid, write_valid, write_address, write_data, byte_count,
		end_code, output ready);
endinterface

FILE: src/pwpi_cfg_if.sv
interface pwpi_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: src/pwpi_cfg_regs.sv
module pwpi_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [31:0]      wr_data,
	output pwpi_pkg::cfg_t   cfg
);

	pwpi_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (pwpi_pkg::cfg_index_t'(wr_index))
				pwpi_pkg::CFG_PROGRAM_KIND: begin
					cfg_q.program_kind <= wr_data[0];
				end
				pwpi_pkg::CFG_FILL_COLOR: begin
					cfg_q.fill_color <= wr_data[7:0];
				end
				pwpi_pkg::CFG_DESTINATION_BASE: begin
					cfg_q.destination_base <= wr_data;
				end
				default: begin
					// unmapped index, dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/pwpi_decoder.sv
module pwpi_decoder (
	input  pwpi_pkg::parse_state_t cur,
	input  pwpi_pkg::cfg_t         cfg,
	input  logic [7:0]             prog_byte,
	input  logic                   first,
	input  logic                   last,
	output pwpi_pkg::parse_state_t nxt,
	output pwpi_pkg::result_t      res,
	output logic                   produce
);

	pwpi_pkg::parse_state_t s;
	pwpi_pkg::end_code_t    endc;
	logic                   wv;
	logic [2:0]             cnt;
	logic [31:0]            data;
	logic [2:0]             idx_inc;
	logic [2:0]             idx_dec;
	logic [2:0]             need;
	logic [31:0]            gather_op;
	logic [31:0]            gather_body;
	logic [7:0]             d_sel;
	logic [pwpi_pkg::AddrWidth-1:0] addr_sum;
	logic                   is_disp;

	always_comb begin
		s = cur;
		if (first) begin
			s.phase    = pwpi_pkg::PH_IDLE;
			s.op_index = '0;
			s.gather   = '0;
			s.disp     = '0;
			s.base     = pwpi_pkg::AddrWidth'(cfg.destination_base);
			s.color    = '0;
			s.loaded   = 1'b0;
			s.halted   = 1'b0;
		end

		idx_inc     = s.op_index + 3'd1;
		idx_dec     = s.op_index - 3'd1;
		gather_op   = s.gather | (32'(prog_byte) << {s.op_index[1:0], 3'b000});
		gather_body = s.gather | (32'(prog_byte) << {idx_dec[1:0], 3'b000});
		is_disp     = (s.phase == pwpi_pkg::PH_F4_DISP) || (s.phase == pwpi_pkg::PH_F2_DISP)
			|| (s.phase == pwpi_pkg::PH_F1_DISP);
		d_sel       = is_disp ? prog_byte : s.disp;
		addr_sum    = s.base + {{(pwpi_pkg::AddrWidth-8){d_sel[7]}}, d_sel};
		case (s.phase)
			pwpi_pkg::PH_I1_BODY: need = 3'd1;
			pwpi_pkg::PH_I2_BODY: need = 3'd2;
			default:              need = 3'd4;
		endcase

		nxt  = s;
		wv   = 1'b0;
		cnt  = '0;
		data = '0;
		endc = pwpi_pkg::END_RUNNING;

		if (!s.halted) begin
			case (s.phase)
				pwpi_pkg::PH_IDLE: begin
					nxt.op_index = '0;
					nxt.gather   = '0;
					if (prog_byte == pwpi_pkg::OP_RET) begin
						endc = pwpi_pkg::END_RETURN;
					end else if (prog_byte == pwpi_pkg::OP_ADVANCE) begin
						nxt.phase = pwpi_pkg::PH_ADV;
					end else if (!cfg.program_kind) begin
						case (prog_byte)
							pwpi_pkg::OP_LOAD:     nxt.phase = pwpi_pkg::PH_COLOR;
							pwpi_pkg::OP_MOV32:    nxt.phase = pwpi_pkg::PH_F4_MOD;
							pwpi_pkg::OP_PREFIX16: nxt.phase = pwpi_pkg::PH_P66;
							pwpi_pkg::OP_MOV8:     nxt.phase = pwpi_pkg::PH_F1_MOD;
							default:               endc = pwpi_pkg::END_MALFORMED;
						endcase
					end else begin
						case (prog_byte)
							pwpi_pkg::OP_IMM8:     nxt.phase = pwpi_pkg::PH_I1_MOD;
							pwpi_pkg::OP_PREFIX16: nxt.phase = pwpi_pkg::PH_P66;
							pwpi_pkg::OP_IMM32:    nxt.phase = pwpi_pkg::PH_I4_MOD;
							default:               endc = pwpi_pkg::END_MALFORMED;
						endcase
					end
				end
				pwpi_pkg::PH_ADV, pwpi_pkg::PH_COLOR: begin
					nxt.gather   = gather_op;
					nxt.op_index = idx_inc;
					if (idx_inc >= 3'd4) begin
						if (s.phase == pwpi_pkg::PH_ADV) begin
							nxt.base = s.base + pwpi_pkg::AddrWidth'(gather_op);
						end else begin
							nxt.color  = s.loaded ? gather_op : {4{cfg.fill_color}};
							nxt.loaded = 1'b1;
						end
						nxt.phase = pwpi_pkg::PH_IDLE;
					end
				end
				pwpi_pkg::PH_P66: begin
					if (!cfg.program_kind && prog_byte == pwpi_pkg::OP_MOV32) begin
						nxt.phase = pwpi_pkg::PH_F2_MOD;
					end else if (cfg.program_kind && prog_byte == pwpi_pkg::OP_IMM32) begin
						nxt.phase = pwpi_pkg::PH_I2_MOD;
					end else begin
						endc = pwpi_pkg::END_MALFORMED;
					end
				end
				pwpi_pkg::PH_F4_MOD, pwpi_pkg::PH_F2_MOD, pwpi_pkg::PH_F1_MOD: begin
					if (prog_byte == pwpi_pkg::OP_MODRM) begin
						nxt.phase = pwpi_pkg::phase_t'(s.phase + 4'd1);
					end else begin
						endc = pwpi_pkg::END_MALFORMED;
					end
				end
				pwpi_pkg::PH_F4_DISP, pwpi_pkg::PH_F2_DISP, pwpi_pkg::PH_F1_DISP: begin
					nxt.disp  = prog_byte;
					wv        = 1'b1;
					nxt.phase = pwpi_pkg::PH_IDLE;
					case (s.phase)
						pwpi_pkg::PH_F4_DISP: begin
							cnt  = 3'd4;
							data = s.color;
						end
						pwpi_pkg::PH_F2_DISP: begin
							cnt  = 3'd2;
							data = {16'h0000, s.color[15:0]};
						end
						default: begin
							cnt  = 3'd1;
							data = {24'h000000, s.color[7:0]};
						end
					endcase
				end
				pwpi_pkg::PH_I1_MOD, pwpi_pkg::PH_I2_MOD, pwpi_pkg::PH_I4_MOD: begin
					if (prog_byte == pwpi_pkg::OP_MODRM_IMM) begin
						nxt.phase    = pwpi_pkg::phase_t'(s.phase + 4'd1);
						nxt.op_index = '0;
						nxt.gather   = '0;
					end else begin
						endc = pwpi_pkg::END_MALFORMED;
					end
				end
				default: begin
					// immediate body: displacement then data bytes
					if (s.op_index == 3'd0) begin
						nxt.disp = prog_byte;
					end else begin
						nxt.gather = gather_body;
					end
					nxt.op_index = idx_inc;
					if (idx_inc >= need + 3'd1) begin
						wv        = 1'b1;
						cnt       = need;
						data      = nxt.gather;
						nxt.phase = pwpi_pkg::PH_IDLE;
					end
				end
			endcase

			if (endc != pwpi_pkg::END_RUNNING) begin
				nxt.halted = 1'b1;
				nxt.phase  = pwpi_pkg::PH_IDLE;
			end else if (last) begin
				endc = (nxt.phase == pwpi_pkg::PH_IDLE) ? pwpi_pkg::END_EXHAUSTED
					: pwpi_pkg::END_MALFORMED;
				nxt.halted = 1'b1;
				nxt.phase  = pwpi_pkg::PH_IDLE;
			end
		end

		produce           = !s.halted && (wv || endc != pwpi_pkg::END_RUNNING);
		res.write_valid   = wv;
		res.write_address = wv ? 32'(addr_sum) : 32'h0;
		res.write_data    = data;
		res.byte_count    = cnt;
		res.end_code      = endc;
	end

endmodule

FILE: src/pixel_write_program_interpreter.sv
// compiled-sprite write-program interpreter: program bytes arrive one byte per
// handshake on prog and each completed store, or the end of the program, leaves
// as one word on result (write_valid, little-endian write_data, byte_count, and
// end_code: 0 running, 1 return, 2 malformed or truncated, 3 buffer exhausted).
// a byte flagged first_byte restarts the parser and loads destination_base; after
// any end the block swallows bytes silently until the next first_byte. throughput
// is one program byte per clock: a byte sits in the input register while the
// decoder works out the next parser state and the result, which is then
// captured in the output register; the only limit is the result consumer, and a
// byte that produces no result never waits on it. the result word is offered from
// the output register once its byte has left the input register. configuration
// writes on cfg are always ready and take effect next cycle; they are meant to be
// made between programs.
module pixel_write_program_interpreter (
	input logic          clk,
	input logic          arst_n,
	pwpi_cfg_if.sink     cfg,
	pwpi_prog_if.sink    prog,
	pwpi_result_if.source result
);

	// handshake views; res_ready is also tapped by the checker
	logic prog_valid;
	logic prog_ready;
	logic res_ready;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;

	// parser state and result register
	pwpi_pkg::parse_state_t state_q;
	pwpi_pkg::parse_state_t state_nxt;
	pwpi_pkg::result_t      res_nxt;
	pwpi_pkg::result_t      res_q;
	logic                   res_valid_q;
	logic                   produce;
	logic                   advance;
	pwpi_pkg::cfg_t         cfg_cur;

	assign prog_valid = prog.valid;
	assign res_ready  = result.ready;

	pwpi_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_cur)
	);
	assign cfg.ready = 1'b1;

	pwpi_decoder u_decoder (
		.cur       (state_q),
		.cfg       (cfg_cur),
		.prog_byte (byte_s1),
		.first     (first_s1),
		.last      (last_s1),
		.nxt       (state_nxt),
		.res       (res_nxt),
		.produce   (produce)
	);

	// the held byte moves on when its result has room, or when it makes none
	assign advance    = valid_s1 && (!res_valid_q || res_ready || !produce);
	assign prog_ready = !valid_s1 || advance;
	assign prog.ready = prog_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (prog_ready) begin
			valid_s1 <= prog_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prog_ready && prog_valid) begin
			byte_s1  <= prog.program_byte;
			first_s1 <= prog.first_byte;
			last_s1  <= prog.last_byte;
		end
	end

	// parser state: halted until the first program starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwpi_pkg::ParseReset;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && produce) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.write_valid   = res_q.write_valid;
	assign result.write_address = res_q.write_address;
	assign result.write_data    = res_q.write_data;
	assign result.byte_count    = res_q.byte_count;
	assign result.end_code      = res_q.end_code;

endmodule

FILE: src/pwpi_checker.sv
module pwpi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        write_valid,
	input logic [31:0] write_address,
	input logic [31:0] write_data,
	input logic [2:0]  byte_count,
	input logic [1:0]  end_code
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(write_valid)
			&& $stable(write_address) && $stable(write_data) && $stable(byte_count)
			&& $stable(end_code))
		else $error("result word changed while stalled");

	// a word without a store is an end notice with empty payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> byte_count == 3'd0 && write_data == 32'h0
			&& write_address == 32'h0 && end_code != pwpi_pkg::END_RUNNING)
		else $error("end word carries payload or no end code");

	// store sizes and unused upper bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> (byte_count == 3'd4)
			|| (byte_count == 3'd2 && write_data[31:16] == 16'h0)
			|| (byte_count == 3'd1 && write_data[31:8] == 24'h0))
		else $error("bad store size or stray data bytes");

	// a store ends a command, so it never shares a word with return or malformed
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> end_code == pwpi_pkg::END_RUNNING
			|| end_code == pwpi_pkg::END_EXHAUSTED)
		else $error("store paired with return or malformed end");

endmodule

bind pixel_write_program_interpreter pwpi_checker u_pwpi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (res_valid_q),
	.out_ready     (res_ready),
	.write_valid   (res_q.write_valid),
	.write_address (res_q.write_address),
	.write_data    (res_q.write_data),
	.byte_count    (res_q.byte_count),
	.end_code      (res_q.end_code)
);
